@@ rtl/core/fcpa_pkg.sv @@
// Shared constants, codes and control types for the fixed chunk pool allocator.
package fcpa_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_CHUNKS = 256;
   localparam int DEF_ADDR_WIDTH = 32;

   // field widths
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_LG_W  = 5;
   localparam int CSR_CNT_W = 9;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NULL       = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LOG2  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT = 2'd2;

   // register reset values and chunk size limits
   localparam logic [CSR_LG_W-1:0]  RST_CHUNK_LOG2  = 5'd4;
   localparam logic [CSR_CNT_W-1:0] RST_CHUNK_COUNT = 9'd256;
   localparam logic [CSR_LG_W-1:0]  LG_MIN          = 5'd3;
   localparam logic [CSR_LG_W-1:0]  LG_MAX          = 5'd16;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic fill_step;
      logic respond;
   } fcpa_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic fill_last;
   } fcpa_stat_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_FILL = 3'b100
   } fcpa_state_type;

endpackage

@@ rtl/core/fcpa_ctrl.sv @@
// Controller state machine for the chunk pool allocator.
module fcpa_ctrl
   import fcpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CMD_W-1:0]    req_cmd,
   input  fcpa_stat_type       dp_stat,
   output fcpa_ctl_type        dp_ctl,
   output logic                busy
);

   fcpa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_ctl   = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_ctl.accept = 1'b1;
               state_in = (req_cmd == CMD_FREE_ALL) ? S_FILL : S_EXEC;
            end
         end
         S_EXEC: begin
            dp_ctl.exec    = 1'b1;
            dp_ctl.respond = 1'b1;
            state_in       = S_IDLE;
         end
         S_FILL: begin
            dp_ctl.fill_step = 1'b1;
            if (dp_stat.fill_last) begin
               dp_ctl.respond = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/core/fcpa_dp.sv @@
// Datapath: registers, free list memory, bounds checks and result registers.
module fcpa_dp
   import fcpa_pkg::*;
#(
   parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
   parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
)(
   input  logic                  clock,
   input  logic                  reset,
   input  fcpa_ctl_type          dp_ctl,
   output fcpa_stat_type         dp_stat,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ADDR_WIDTH-1:0] req_addr,
   input  logic                  req_is_null,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_WIDTH-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_WIDTH-1:0] rsp_chunk_addr
);

   localparam int IDX_W  = $clog2(MAX_CHUNKS);
   localparam int HEAD_W = $clog2(MAX_CHUNKS + 1);
   localparam int CW     = (HEAD_W > CSR_CNT_W) ? HEAD_W : CSR_CNT_W;
   localparam int W2     = (ADDR_WIDTH > HEAD_W) ? ADDR_WIDTH : HEAD_W;
   localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_CHUNKS);

   // configuration
   logic [ADDR_WIDTH-1:0] base_ff;
   logic [CSR_LG_W-1:0]   lg_ff;
   logic [CSR_CNT_W-1:0]  count_ff;

   // list state and latched item
   logic [HEAD_W-1:0]     head_ff, head_in;
   logic [HEAD_W-1:0]     fill_ff, fill_in;
   logic [HEAD_W-1:0]     rd_data_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic                  null_ff;
   logic [HEAD_W-1:0]     mem [MAX_CHUNKS];

   // results
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ADDR_WIDTH-1:0] caddr_ff, caddr_in;

   logic [CSR_LG_W-1:0]   lg_eff;
   logic [CW-1:0]         count_ext;
   logic [HEAD_W-1:0]     cnt_eff;
   logic [ADDR_WIDTH-1:0] offset, idx_full, align_mask;
   logic                  in_range, aligned, list_empty, fill_active;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [HEAD_W-1:0]     mem_wd;

   function automatic logic [ADDR_WIDTH-1:0] req_addr_sel(
      input logic [ADDR_WIDTH-1:0] a,
      input logic [ADDR_WIDTH-1:0] b
   );
      return a - b;
   endfunction

   always_comb begin
      if (lg_ff < LG_MIN) begin
         lg_eff = LG_MIN;
      end else if (lg_ff > LG_MAX) begin
         lg_eff = LG_MAX;
      end else begin
         lg_eff = lg_ff;
      end
      count_ext = CW'(count_ff);
      cnt_eff   = (count_ext > CW'(MAX_CHUNKS)) ? EMPTY_MARK : HEAD_W'(count_ext);
   end

   assign offset      = req_addr_sel(addr_ff, base_ff);
   assign idx_full    = offset >> lg_eff;
   assign align_mask  = ~({ADDR_WIDTH{1'b1}} << lg_eff);
   assign aligned     = ((offset & align_mask) == '0);
   assign in_range    = (W2'(idx_full) < W2'(cnt_eff));
   assign list_empty  = (head_ff == EMPTY_MARK);
   assign fill_active = (fill_ff < cnt_eff);

   assign dp_stat.fill_last = (({1'b0, fill_ff} + 1'b1) >= {1'b0, cnt_eff});

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      status_in = STAT_OK;
      caddr_in  = '0;
      mem_we    = 1'b0;
      mem_wa    = idx_full[IDX_W-1:0];
      mem_wd    = head_ff;

      if (dp_ctl.accept) begin
         fill_in = '0;
         if (req_cmd == CMD_FREE_ALL) begin
            head_in = EMPTY_MARK;
         end
      end

      case (cmd_ff)
         CMD_ALLOC: begin
            if (list_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               caddr_in = base_ff + (ADDR_WIDTH'(head_ff) << lg_eff);
               if (dp_ctl.exec) begin
                  head_in = rd_data_ff;
               end
            end
         end
         CMD_FREE: begin
            if (null_ff) begin
               status_in = STAT_NULL;
            end else if (!in_range) begin
               status_in = STAT_RANGE;
            end else if (!aligned) begin
               status_in = STAT_MISALIGNED;
            end else if (dp_ctl.exec) begin
               mem_we  = 1'b1;
               head_in = idx_full[HEAD_W-1:0];
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase

      // free_all rebuild: next[i] = previous head, head = i
      if (dp_ctl.fill_step && fill_active) begin
         mem_we  = 1'b1;
         mem_wa  = fill_ff[IDX_W-1:0];
         mem_wd  = head_ff;
         head_in = fill_ff;
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (dp_ctl.accept) begin
         rd_data_ff <= mem[head_ff[IDX_W-1:0]];
         cmd_ff     <= req_cmd;
         addr_ff    <= req_addr;
         null_ff    <= req_is_null;
      end
      if (dp_ctl.respond) begin
         status_ff <= status_in;
         caddr_ff  <= caddr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         lg_ff        <= RST_CHUNK_LOG2;
         count_ff     <= RST_CHUNK_COUNT;
         head_ff      <= EMPTY_MARK;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= dp_ctl.respond;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_ADDR:   base_ff  <= csr_wdata;
               CSR_CHUNK_LOG2:  lg_ff    <= csr_wdata[CSR_LG_W-1:0];
               CSR_CHUNK_COUNT: count_ff <= csr_wdata[CSR_CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_chunk_addr = caddr_ff;

endmodule

@@ rtl/core/fixed_chunk_pool_allocator_core.sv @@
// Alloc and free: item registered on accept, handled in the exec state, no new item taken
// meanwhile; the result comes after the registered next-index memory read and head update.
// Free_all: writes one next-index entry per cycle, result after the last one; the next item
// can be taken while rsp_valid is high. Receiver cannot stall: rsp_valid lasts one cycle.
// Reset: free list empty, registers at defaults; the next-index memory is not cleared.
module fixed_chunk_pool_allocator_core
   import fcpa_pkg::*;
#(
   parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
   parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ADDR_WIDTH-1:0] req_addr,
   input  logic                  req_is_null,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_WIDTH-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_WIDTH-1:0] rsp_chunk_addr
);

   fcpa_ctl_type  dp_ctl;
   fcpa_stat_type dp_stat;

   fcpa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .dp_stat (dp_stat),
      .dp_ctl  (dp_ctl),
      .busy    (busy)
   );

   fcpa_dp #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_ctl         (dp_ctl),
      .dp_stat        (dp_stat),
      .req_cmd        (req_cmd),
      .req_addr       (req_addr),
      .req_is_null    (req_is_null),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_chunk_addr (rsp_chunk_addr)
   );

endmodule
